@@ design/idrot_pkg.sv @@
// Shared types and constants for the id range ownership table.
`default_nettype none

package idrot_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int OWNER_W    = 8;
  localparam int ID_W       = 32;
  localparam int CFG_IDX_W  = 8;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_RESOLVE    = 2'd1,
    CMD_UNREGISTER = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_HALF_TOP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_USER_HALF_START = CFG_IDX_W'(1);

  typedef struct packed {
    logic               active;
    logic               commit;
    logic [1:0]         cmd;
    logic [ID_W-1:0]    lo;
    logic [ID_W-1:0]    hi;
    logic [OWNER_W-1:0] owner;
    logic [ID_W-1:0]    qid;
    logic               hit;
    logic [OWNER_W-1:0] hit_owner;
    logic               free_seen;
    logic               claimed;
  } tok_t;

endpackage

`default_nettype wire

@@ design/id_range_ownership_table.sv @@
// Top level of the id range ownership table: command control, config and result word.
//
//   channel | signals                                          | role
//   in      | in_valid in_ready command range_min range_max   | command word
//           | owner_tag query_id                               |
//   out     | out_valid out_ready status found found_owner    | result word
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data          | register write
//
// One command word is in flight at a time. A rejected or unknown command goes straight
// to its result; resolve and unregister send the token along the slot chain once;
// a successful register walks it twice. Reset clears all slots at once. A stalled result
// holds the next finished one back, and no command word is taken until the chain is free.
`default_nettype none

module id_range_ownership_table
  import idrot_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           command,
  input  wire logic [ID_W-1:0]      range_min,
  input  wire logic [ID_W-1:0]      range_max,
  input  wire logic [OWNER_W-1:0]   owner_tag,
  input  wire logic [ID_W-1:0]      query_id,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                status,
  output logic                      found,
  output logic [OWNER_W-1:0]        found_owner,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ID_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_COMMIT, S_DONE} state_t;

  state_t             state;
  logic               inject;
  logic               commit;
  logic [1:0]         cmd;
  logic [ID_W-1:0]    lo;
  logic [ID_W-1:0]    hi;
  logic [OWNER_W-1:0] owner;
  logic [ID_W-1:0]    qid;
  status_e            res_status;
  logic               res_found;
  logic [OWNER_W-1:0] res_owner;
  logic [ID_W-1:0]    engine_half_top;
  logic [ID_W-1:0]    user_half_start;
  tok_t               head;
  tok_t               tail;
  logic               in_fire;
  logic               bad_reg;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  assign bad_reg = (owner_tag == '0) || (range_min > range_max) ||
                   (!(range_max <= engine_half_top) && !(range_min >= user_half_start));

  always_comb begin
    head           = '0;
    head.active    = inject;
    head.commit    = commit;
    head.cmd       = cmd;
    head.lo        = lo;
    head.hi        = hi;
    head.owner     = owner;
    head.qid       = qid;
  end

  idrot_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .tail (tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_half_top <= ID_W'(65535);
      user_half_start <= ID_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ENGINE_HALF_TOP) begin
        engine_half_top <= cfg_data;
      end else if (cfg_index == REG_USER_HALF_START) begin
        user_half_start <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd   <= command;
      lo    <= range_min;
      hi    <= range_max;
      owner <= owner_tag;
      qid   <= query_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inject    <= 1'b0;
      commit    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      inject <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_status <= ST_OK;
            res_found  <= 1'b0;
            res_owner  <= '0;
            commit     <= 1'b0;
            case (command)
              CMD_REGISTER: begin
                if (bad_reg) begin
                  res_status <= ST_BAD;
                  state      <= S_DONE;
                end else begin
                  inject <= 1'b1;
                  state  <= S_CHECK;
                end
              end
              CMD_RESOLVE, CMD_UNREGISTER: begin
                inject <= 1'b1;
                state  <= S_CHECK;
              end
              default: begin
                res_status <= ST_BAD;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (tail.active) begin
            case (tail.cmd)
              CMD_REGISTER: begin
                if (tail.hit) begin
                  res_status <= ST_OVERLAP;
                  state      <= S_DONE;
                end else if (!tail.free_seen) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  commit <= 1'b1;
                  inject <= 1'b1;
                  state  <= S_COMMIT;
                end
              end
              CMD_RESOLVE: begin
                res_found <= tail.hit;
                res_owner <= tail.hit ? tail.hit_owner : '0;
                state     <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_COMMIT: begin
          if (tail.active) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found       <= res_found;
            found_owner <= res_owner;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_tail_when_waiting: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> (state == S_CHECK || state == S_COMMIT))
    else $error("token left the chain while control was not waiting");

  a_inject_pulse: assert property (@(posedge clk) disable iff (rst)
    inject |=> !inject)
    else $error("token injected on two cycles in a row");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("accepted a word while the previous one was in flight");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == ST_OK && found_owner != '0))
    else $error("found result with bad status or empty owner");
`endif

endmodule

`default_nettype wire

@@ design/idrot_cell.sv @@
// One table slot that inspects and forwards the command token.
`default_nettype none

module idrot_cell
  import idrot_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t tok_in,
  output tok_t      tok_out
);

  logic               valid;
  logic               valid_next;
  logic [ID_W-1:0]    low;
  logic [ID_W-1:0]    high;
  logic [OWNER_W-1:0] owner;
  logic               wr;
  tok_t               tok_next;

  always_comb begin
    tok_next   = tok_in;
    valid_next = valid;
    wr         = 1'b0;
    if (tok_in.active) begin
      case (tok_in.cmd)
        CMD_REGISTER: begin
          if (!tok_in.commit) begin
            if (valid && low <= tok_in.hi && tok_in.lo <= high) begin
              tok_next.hit = 1'b1;
            end
            if (!valid) begin
              tok_next.free_seen = 1'b1;
            end
          end else if (!valid && !tok_in.claimed) begin
            wr               = 1'b1;
            valid_next       = 1'b1;
            tok_next.claimed = 1'b1;
          end
        end
        CMD_RESOLVE: begin
          if (!tok_in.hit && valid && low <= tok_in.qid && tok_in.qid <= high) begin
            tok_next.hit       = 1'b1;
            tok_next.hit_owner = owner;
          end
        end
        CMD_UNREGISTER: begin
          if (valid && owner == tok_in.owner) begin
            valid_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      low   <= tok_in.lo;
      high  <= tok_in.hi;
      owner <= tok_in.owner;
    end
  end

endmodule

`default_nettype wire

@@ design/idrot_chain.sv @@
// Row of table slots that passes the command token one slot per cycle.
`default_nettype none

module idrot_chain
  import idrot_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t head,
  output tok_t      tail
);

  tok_t link [MAX_SLOTS];

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      idrot_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (head),
        .tok_out (link[i])
      );
    end else begin : g_rest
      idrot_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (link[i-1]),
        .tok_out (link[i])
      );
    end
  end

  assign tail = link[MAX_SLOTS-1];

endmodule

`default_nettype wire

@@ dv/tb_id_range_ownership_table.sv @@
// Self-checking bench: directed and random command words, each result word checked against a registry predictor.
`timescale 1ns / 1ps

module tb_id_range_ownership_table;
  import idrot_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ID_W-1:0]    lo;
    logic [ID_W-1:0]    hi;
    logic [OWNER_W-1:0] owner;
    logic [ID_W-1:0]    qid;
  } cmd_word_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [OWNER_W-1:0] owner;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           command = '0;
  logic [ID_W-1:0]      range_min = '0;
  logic [ID_W-1:0]      range_max = '0;
  logic [OWNER_W-1:0]   owner_tag = '0;
  logic [ID_W-1:0]      query_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic                 found;
  logic [OWNER_W-1:0]   found_owner;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ID_W-1:0]      cfg_data = '0;

  id_range_ownership_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .range_min(range_min), .range_max(range_max),
    .owner_tag(owner_tag), .query_id(query_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found(found), .found_owner(found_owner),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  cmd_word_t cmd_q[$];
  reply_t    reply_q[$];
  cmd_word_t next_word;
  cmd_word_t taken_word;
  reply_t    got_reply;

  logic               slot_used [MAX_SLOTS];
  logic [ID_W-1:0]    slot_first [MAX_SLOTS];
  logic [ID_W-1:0]    slot_last [MAX_SLOTS];
  logic [OWNER_W-1:0] slot_tag [MAX_SLOTS];
  logic [ID_W-1:0]    cur_engine_top = 32'd65535;
  logic [ID_W-1:0]    cur_user_start = 32'd65536;

  logic [ID_W-1:0] g_eng = 32'd65535;
  logic [ID_W-1:0] g_usr = 32'd65536;
  logic [ID_W-1:0] seen_lo [8];
  logic [ID_W-1:0] seen_hi [8];
  int              seen_at = 0;

  bit in_fire = 1'b0;
  bit calm = 1'b0;
  bit tx_pause = 1'b0;
  int stall_asks = 0;
  int stall_served = 0;
  int hold_left = 0;
  int words_taken = 0;
  int replies_seen = 0;
  int settings_used = 1;
  int mismatches = 0;
  int n_stored = 0;
  int n_overlap = 0;
  int n_full = 0;
  int n_hits = 0;

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < 8; i++) begin
      seen_lo[i] = '0;
      seen_hi[i] = '0;
    end
  end

  function automatic reply_t registry_apply(cmd_word_t w);
    reply_t r;
    bit     clash;
    r = '{status: ST_OK, found: 1'b0, owner: '0};
    clash = 1'b0;
    case (w.cmd)
      CMD_REGISTER: begin
        if (w.owner == '0 || w.lo > w.hi ||
            (w.hi > cur_engine_top && w.lo < cur_user_start)) begin
          r.status = ST_BAD;
        end else begin
          for (int i = 0; i < MAX_SLOTS; i++)
            if (slot_used[i] && slot_first[i] <= w.hi && w.lo <= slot_last[i]) clash = 1'b1;
          if (clash) begin
            r.status = ST_OVERLAP;
            n_overlap++;
          end else begin
            r.status = ST_FULL;
            for (int i = 0; i < MAX_SLOTS; i++) begin
              if (!slot_used[i] && r.status == ST_FULL) begin
                slot_used[i] = 1'b1;
                slot_first[i] = w.lo;
                slot_last[i] = w.hi;
                slot_tag[i] = w.owner;
                r.status = ST_OK;
              end
            end
            if (r.status == ST_OK) n_stored++;
            else n_full++;
          end
        end
      end
      CMD_RESOLVE: begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          if (!r.found && slot_used[i] && slot_first[i] <= w.qid && w.qid <= slot_last[i]) begin
            r.found = 1'b1;
            r.owner = slot_tag[i];
          end
        end
        if (r.found) n_hits++;
      end
      CMD_UNREGISTER: begin
        for (int i = 0; i < MAX_SLOTS; i++)
          if (slot_used[i] && slot_tag[i] == w.owner) slot_used[i] = 1'b0;
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 11);
  endfunction

  function automatic logic [OWNER_W-1:0] pool_owner();
    if ($urandom_range(9) == 0) return OWNER_W'($urandom_range(255, 1));
    return OWNER_W'($urandom_range(7, 1));
  endfunction

  function automatic cmd_word_t make_word();
    cmd_word_t  w;
    int         pick;
    int         k;
    logic [32:0] base;
    w.cmd = CMD_RESOLVE;
    w.lo = $urandom;
    w.hi = $urandom;
    w.owner = OWNER_W'($urandom);
    w.qid = $urandom;
    pick = $urandom_range(99);
    k = $urandom_range(31);
    if (pick < 40) begin
      w.cmd = CMD_REGISTER;
      w.owner = pool_owner();
      if ($urandom_range(1)) base = 33'(k * 64 + $urandom_range(3));
      else base = {1'b0, g_usr} + 33'(k * 64 + $urandom_range(3));
      w.lo = base[32] ? '1 : base[ID_W-1:0];
      base = {1'b0, w.lo} + 33'($urandom_range(($urandom_range(7) == 0) ? 200 : 60));
      w.hi = base[32] ? '1 : base[ID_W-1:0];
      seen_lo[seen_at] = w.lo;
      seen_hi[seen_at] = w.hi;
      seen_at = (seen_at + 1) % 8;
    end else if (pick < 45) begin
      w.cmd = CMD_REGISTER;
      case ($urandom_range(2))
        0: begin
          w.owner = '0;
          w.lo = $urandom_range(2000);
          w.hi = w.lo + $urandom_range(50);
        end
        1: begin
          w.owner = pool_owner();
          w.lo = w.hi + 1 + $urandom_range(100);
        end
        default: begin
          w.owner = pool_owner();
          w.lo = g_eng - $urandom_range(20);
          w.hi = g_usr + $urandom_range(20);
        end
      endcase
    end else if (pick < 75) begin
      k = $urandom_range(7);
      case ($urandom_range(6))
        0: w.qid = seen_lo[k];
        1: w.qid = seen_hi[k];
        2: w.qid = seen_lo[k] - 1;
        3: w.qid = seen_hi[k] + 1;
        4: w.qid = seen_lo[k] + (seen_hi[k] - seen_lo[k]) / 2;
        5: w.qid = $urandom_range(1) ? '1 : '0;
        default: ;
      endcase
    end else if (pick < 85) begin
      w.cmd = CMD_UNREGISTER;
      if ($urandom_range(9) == 0) w.owner = '0;
      else w.owner = pool_owner();
    end else begin
      w.cmd = 2'($urandom_range(3));
    end
    return w;
  endfunction

  task automatic push(input logic [1:0] c, input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi,
                      input logic [OWNER_W-1:0] own, input logic [ID_W-1:0] q);
    cmd_word_t w;
    w = '{cmd: c, lo: lo, hi: hi, owner: own, qid: q};
    cmd_q.insert(cmd_q.size(), w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ENGINE_HALF_TOP) g_eng = val;
    else g_usr = val;
  endtask

  task automatic set_halves(input logic [ID_W-1:0] eng, input logic [ID_W-1:0] usr);
    write_reg(REG_ENGINE_HALF_TOP, eng);
    write_reg(REG_USER_HALF_START, usr);
    settings_used++;
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_random(input int n);
    cmd_word_t w;
    repeat (n) begin
      w = make_word();
      cmd_q.insert(cmd_q.size(), w);
    end
  endtask

  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      taken_word = '{cmd: command, lo: range_min, hi: range_max, owner: owner_tag, qid: query_id};
      reply_q.insert(reply_q.size(), registry_apply(taken_word));
      words_taken++;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENGINE_HALF_TOP: cur_engine_top = cfg_data;
        REG_USER_HALF_START: cur_user_start = cfg_data;
        default: ;
      endcase
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (cmd_q.size() != 0 && !tx_pause && !take_break()) begin
        next_word = cmd_q.pop_front();
        in_valid <= 1'b1;
        command <= next_word.cmd;
        range_min <= next_word.lo;
        range_max <= next_word.hi;
        owner_tag <= next_word.owner;
        query_id <= next_word.qid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_asks != stall_served) begin
      stall_served = stall_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        $error("result word with no command word outstanding");
        mismatches++;
      end else begin
        got_reply = reply_q.pop_front();
        if (status !== got_reply.status) begin
          $error("field status expected %0d actual %0d", got_reply.status, status);
          mismatches++;
        end
        if (found !== got_reply.found) begin
          $error("field found expected %0d actual %0d", got_reply.found, found);
          mismatches++;
        end
        if (found_owner !== got_reply.owner) begin
          $error("field found_owner expected %0d actual %0d", got_reply.owner, found_owner);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int base_count;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push(CMD_REGISTER, 32'd100, 32'd200, 8'd0, $urandom);
    push(CMD_REGISTER, 32'd300, 32'd299, 8'd1, $urandom);
    push(CMD_REGISTER, 32'd65535, 32'd65536, 8'd1, $urandom);
    push(CMD_REGISTER, 32'd0, 32'd0, 8'd1, $urandom);
    push(CMD_REGISTER, '1, '1, 8'd255, $urandom);
    push(CMD_REGISTER, 32'd65535, 32'd65535, 8'd2, $urandom);
    push(CMD_REGISTER, 32'd65536, 32'd70000, 8'd3, $urandom);
    push(CMD_REGISTER, 32'd69999, 32'd80000, 8'd4, $urandom);
    push(CMD_RESOLVE, $urandom, $urandom, 8'($urandom), 32'd0);
    push(CMD_RESOLVE, $urandom, $urandom, 8'($urandom), '1);
    push(CMD_RESOLVE, $urandom, $urandom, 8'($urandom), 32'd70001);
    push(CMD_UNKNOWN, '1, '1, '1, '1);
    push(CMD_UNREGISTER, $urandom, $urandom, 8'd0, $urandom);
    for (int i = 0; i < 12; i++)
      push(CMD_REGISTER, 32'(100 + i * 16), 32'(107 + i * 16), 8'(i % 3 + 4), $urandom);
    push(CMD_REGISTER, 32'd5000, 32'd5000, 8'd9, $urandom);
    push(CMD_UNREGISTER, $urandom, $urandom, 8'd255, $urandom);
    push(CMD_RESOLVE, $urandom, $urandom, 8'($urandom), '1);
    add_random(470);
    drain();

    set_halves('1, '0);
    base_count = words_taken;
    add_random(400);
    while (words_taken < base_count + 100) @(posedge clk);
    stall_asks++;
    drain();

    set_halves('0, '1);
    add_random(100);
    drain();

    set_halves(32'd3000, 32'h8000_0000);
    calm = 1'b1;
    base_count = words_taken;
    add_random(400);
    while (words_taken < base_count + 150) @(posedge clk);
    tx_pause = 1'b1;
    while (in_valid || reply_q.size() != 0) @(posedge clk);
    tx_pause = 1'b0;
    drain();
    calm = 1'b0;

    set_halves(32'h0010_0000 + $urandom_range(32'h00FF_FFFF), $urandom_range(32'h000F_FFFF));
    add_random(300);
    drain();

    set_halves(32'd65535, 32'd65536);
    add_random(300);
    drain();

    repeat (2 * MAX_SLOTS + 8) @(posedge clk);
    $display("Ran %0d command words and %0d result words over %0d half boundary settings.",
             words_taken, replies_seen, settings_used);
    $display("Ranges stored %0d, overlaps %0d, table full %0d, resolve hits %0d.",
             n_stored, n_overlap, n_full, n_hits);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d result words still expected.", reply_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
